### rtl/core/erq_pkg.sv
package erq_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = 5;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [1:0]        sstate_t;
    typedef logic [1:0]        mode_t;

    localparam mode_t MODE_TRIGGER = 2'd0;
    localparam mode_t MODE_CANCEL  = 2'd1;
    localparam mode_t MODE_TAKE    = 2'd2;
    localparam mode_t MODE_FINISH  = 2'd3;

    localparam sstate_t ST_IDLE    = 2'd0;
    localparam sstate_t ST_PENDING = 2'd1;
    localparam sstate_t ST_EXEC    = 2'd2;
    localparam sstate_t ST_RETRIG  = 2'd3;

endpackage

### rtl/core/event_ready_queue.sv
// Ready queue for NUM_SLOTS event slots, each idle, pending, executing or
// executing with a retrigger. Pending slots form a FIFO held as a doubly
// linked list in two link RAMs; slot states sit in a third RAM.
//
// Command channel: a word (mode, slot) is taken at a rising edge with start
// high and busy low. Modes: trigger, cancel, take head, finish execution.
// The command's RAM reads are issued at that edge; the next cycle (busy high)
// evaluates the operation and writes the RAMs back. In the cycle after that the result
// word (taken_slot, taken, slot_state, ignored, queue_nonempty) is shown for
// exactly one cycle with done high. The receiver cannot stall.
//
// A new command may be given in the done cycle, but not while the block is
// busy evaluating the last one, because of the read-then-write pass over the
// state and link RAMs.
//
// Reset (rst_n low) empties the queue, clears the running slot and makes all
// slots read as idle through per-slot valid flags; no clearing pass is needed.
module event_ready_queue
    import erq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  mode_t   mode,
    input  slot_t   slot,
    output logic    busy,
    output logic    done,
    output slot_t   taken_slot,
    output logic    taken,
    output sstate_t slot_state,
    output logic    ignored,
    output logic    queue_nonempty
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [1:0] phase_reg, phase_next;

    slot_t head_reg, head_next;
    slot_t tail_reg, tail_next;
    logic  has_reg, has_next;
    slot_t run_slot_reg, run_slot_next;
    logic  run_vld_reg, run_vld_next;
    logic [NUM_SLOTS-1:0] vld_reg, vld_next;

    mode_t op_mode_reg;
    slot_t op_addr_reg;
    logic  op_inrange_reg;
    logic  st_vld_reg;

    slot_t   taken_slot_reg, taken_slot_next;
    logic    taken_reg, taken_next;
    sstate_t slot_state_reg, slot_state_next;
    logic    ignored_reg, ignored_next;
    logic    nonempty_reg;

    logic    accept;
    slot_t   rd_addr;

    logic    st_we, nx_we, pv_we;
    slot_t   nx_waddr, pv_waddr, nx_wdata, pv_wdata;
    sstate_t st_wdata, st_rdata, cur_st;
    slot_t   nx_rdata, pv_rdata;

    assign accept = start && (phase_reg != PH_RUN);
    assign busy   = (phase_reg == PH_RUN);
    assign done   = (phase_reg == PH_DONE);

    always_comb
    begin
        unique case (mode)
            MODE_TAKE:   rd_addr = head_reg;
            MODE_FINISH: rd_addr = run_slot_reg;
            default:     rd_addr = slot;
        endcase
    end

    erq_ram #(.WIDTH(2), .DEPTH(NUM_SLOTS)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (op_addr_reg),
        .wdata (st_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (st_rdata)
    );

    erq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (nx_rdata)
    );

    erq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (pv_rdata)
    );

    // never-written entries read as idle
    assign cur_st = st_vld_reg ? st_rdata : ST_IDLE;

    always_comb
    begin
        logic do_append;
        logic do_unlink;
        logic at_head;
        logic at_tail;

        phase_next      = phase_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        has_next        = has_reg;
        run_slot_next   = run_slot_reg;
        run_vld_next    = run_vld_reg;
        vld_next        = vld_reg;
        taken_slot_next = '0;
        taken_next      = 1'b0;
        slot_state_next = ST_IDLE;
        ignored_next    = 1'b0;
        st_we           = 1'b0;
        st_wdata        = ST_IDLE;
        nx_we           = 1'b0;
        nx_waddr        = tail_reg;
        nx_wdata        = op_addr_reg;
        pv_we           = 1'b0;
        pv_waddr        = op_addr_reg;
        pv_wdata        = tail_reg;
        do_append       = 1'b0;
        do_unlink       = 1'b0;
        at_head         = (op_addr_reg == head_reg);
        at_tail         = (op_addr_reg == tail_reg);

        unique case (phase_reg)
            PH_RUN:
            begin
                phase_next = PH_DONE;
                unique case (op_mode_reg)
                    MODE_TRIGGER:
                    begin
                        if (!op_inrange_reg)
                        begin
                            ignored_next = 1'b1;
                        end
                        else if (cur_st == ST_IDLE)
                        begin
                            do_append       = 1'b1;
                            st_we           = 1'b1;
                            st_wdata        = ST_PENDING;
                            slot_state_next = ST_PENDING;
                        end
                        else if (cur_st == ST_EXEC)
                        begin
                            st_we           = 1'b1;
                            st_wdata        = ST_RETRIG;
                            slot_state_next = ST_RETRIG;
                        end
                        else
                        begin
                            ignored_next    = 1'b1;
                            slot_state_next = cur_st;
                        end
                    end
                    MODE_CANCEL:
                    begin
                        if (!op_inrange_reg || cur_st == ST_IDLE)
                        begin
                            ignored_next = 1'b1;
                        end
                        else
                        begin
                            do_unlink = (cur_st == ST_PENDING);
                            st_we     = 1'b1;
                            st_wdata  = ST_IDLE;
                        end
                    end
                    MODE_TAKE:
                    begin
                        // the read address was the head
                        if (run_vld_reg || !has_reg)
                        begin
                            ignored_next = 1'b1;
                        end
                        else
                        begin
                            do_unlink       = 1'b1;
                            st_we           = 1'b1;
                            st_wdata        = ST_EXEC;
                            run_slot_next   = op_addr_reg;
                            run_vld_next    = 1'b1;
                            taken_next      = 1'b1;
                            taken_slot_next = op_addr_reg;
                            slot_state_next = ST_EXEC;
                        end
                    end
                    MODE_FINISH:
                    begin
                        if (!run_vld_reg)
                        begin
                            ignored_next = 1'b1;
                        end
                        else
                        begin
                            run_vld_next    = 1'b0;
                            slot_state_next = cur_st;
                            if (cur_st == ST_RETRIG)
                            begin
                                do_append       = 1'b1;
                                st_we           = 1'b1;
                                st_wdata        = ST_PENDING;
                                slot_state_next = ST_PENDING;
                            end
                            else if (cur_st == ST_EXEC)
                            begin
                                st_we           = 1'b1;
                                st_wdata        = ST_IDLE;
                                slot_state_next = ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        ignored_next = 1'b1;
                    end
                endcase

                if (do_append)
                begin
                    pv_we    = 1'b1;
                    pv_waddr = op_addr_reg;
                    pv_wdata = tail_reg;
                    if (has_reg)
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = tail_reg;
                        nx_wdata = op_addr_reg;
                    end
                    else
                    begin
                        head_next = op_addr_reg;
                    end
                    tail_next = op_addr_reg;
                    has_next  = 1'b1;
                end

                if (do_unlink)
                begin
                    priority if (at_head && at_tail)
                    begin
                        has_next = 1'b0;
                    end
                    else if (at_head)
                    begin
                        head_next = nx_rdata;
                    end
                    else if (at_tail)
                    begin
                        tail_next = pv_rdata;
                    end
                    else
                    begin
                        nx_we    = 1'b1;
                        nx_waddr = pv_rdata;
                        nx_wdata = nx_rdata;
                        pv_we    = 1'b1;
                        pv_waddr = nx_rdata;
                        pv_wdata = pv_rdata;
                    end
                end

                if (st_we)
                begin
                    vld_next[op_addr_reg] = 1'b1;
                end
            end
            PH_IDLE, PH_DONE:
            begin
                phase_next = accept ? PH_RUN : PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            has_reg      <= 1'b0;
            run_slot_reg <= '0;
            run_vld_reg  <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            has_reg      <= has_next;
            run_slot_reg <= run_slot_next;
            run_vld_reg  <= run_vld_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg    <= mode;
            op_addr_reg    <= rd_addr;
            op_inrange_reg <= (int'(slot) < NUM_SLOTS);
            st_vld_reg     <= vld_reg[rd_addr];
        end
        if (phase_reg == PH_RUN)
        begin
            taken_slot_reg <= taken_slot_next;
            taken_reg      <= taken_next;
            slot_state_reg <= slot_state_next;
            ignored_reg    <= ignored_next;
            nonempty_reg   <= has_next;
        end
    end

    assign taken_slot     = taken_slot_reg;
    assign taken          = taken_reg;
    assign slot_state     = slot_state_reg;
    assign ignored        = ignored_reg;
    assign queue_nonempty = nonempty_reg;

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start evaluation");

    a_run_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("evaluation not followed by a single result cycle");

    a_taken_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && taken) |-> (!ignored && slot_state == ST_EXEC))
        else $error("taken result with wrong state or ignored flag");

    a_run_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(run_vld_reg) |-> (done && taken && taken_slot == run_slot_reg))
        else $error("running slot set without a take");

    a_empty_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && op_mode_reg == MODE_TAKE && (!has_reg || run_vld_reg)) |=> !taken)
        else $error("take delivered from empty queue or while running");

endmodule

### rtl/core/erq_ram.sv
module erq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### tb/erq_checker.sv
`timescale 1ns / 100ps

// Watches the command and result channels of event_ready_queue, keeps its own
// copy of the slot states and link lists, and compares every result word.
module erq_checker
    import erq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  mode_t   mode,
    input  slot_t   slot,
    input  logic    done,
    input  slot_t   taken_slot,
    input  logic    taken,
    input  sstate_t slot_state,
    input  logic    ignored,
    input  logic    queue_nonempty,
    output int      errors,
    output int      outstanding
);

    typedef struct packed {
        slot_t   taken_slot;
        logic    taken;
        sstate_t slot_state;
        logic    ignored;
        logic    queue_nonempty;
    } result_word_t;

    sstate_t      slot_st [NUM_SLOTS];
    slot_t        next_of [NUM_SLOTS];
    slot_t        prev_of [NUM_SLOTS];
    slot_t        head;
    slot_t        tail;
    logic         q_has;
    slot_t        run_slot;
    logic         run_valid;
    result_word_t due_results[$];

    function automatic void clear_model();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_st[i] = ST_IDLE;
            next_of[i] = '0;
            prev_of[i] = '0;
        end
        head      = '0;
        tail      = '0;
        q_has     = 1'b0;
        run_slot  = '0;
        run_valid = 1'b0;
    endfunction

    function automatic void push_tail(slot_t s);
        prev_of[s] = tail;
        if (q_has)
            next_of[tail] = s;
        else
            head = s;
        tail  = s;
        q_has = 1'b1;
    endfunction

    function automatic void unlink(slot_t s);
        slot_t nx;
        slot_t pv;
        nx = next_of[s];
        pv = prev_of[s];
        if (s == head && s == tail)
            q_has = 1'b0;
        else if (s == head)
            head = nx;
        else if (s == tail)
            tail = pv;
        else
        begin
            next_of[pv] = nx;
            prev_of[nx] = pv;
        end
    endfunction

    function automatic result_word_t run_command(mode_t m, slot_t s);
        result_word_t r;
        slot_t        h;
        r = '0;
        case (m)
            MODE_TRIGGER, MODE_CANCEL:
            begin
                if (int'(s) >= NUM_SLOTS)
                    r.ignored = 1'b1;
                else if (m == MODE_TRIGGER)
                begin
                    if (slot_st[s] == ST_IDLE)
                    begin
                        push_tail(s);
                        slot_st[s] = ST_PENDING;
                    end
                    else if (slot_st[s] == ST_EXEC)
                        slot_st[s] = ST_RETRIG;
                    else
                        r.ignored = 1'b1;
                    r.slot_state = slot_st[s];
                end
                else
                begin
                    if (slot_st[s] == ST_IDLE)
                        r.ignored = 1'b1;
                    else
                    begin
                        if (slot_st[s] == ST_PENDING)
                            unlink(s);
                        // a running slot only goes idle; it stays running till finish
                        slot_st[s] = ST_IDLE;
                    end
                    r.slot_state = slot_st[s];
                end
            end
            MODE_TAKE:
            begin
                if (run_valid || !q_has)
                    r.ignored = 1'b1;
                else
                begin
                    h = head;
                    unlink(h);
                    slot_st[h]   = ST_EXEC;
                    run_slot     = h;
                    run_valid    = 1'b1;
                    r.taken_slot = h;
                    r.taken      = 1'b1;
                    r.slot_state = ST_EXEC;
                end
            end
            default:
            begin
                if (!run_valid)
                    r.ignored = 1'b1;
                else
                begin
                    h = run_slot;
                    if (slot_st[h] == ST_RETRIG)
                    begin
                        push_tail(h);
                        slot_st[h] = ST_PENDING;
                    end
                    else if (slot_st[h] == ST_EXEC)
                        slot_st[h] = ST_IDLE;
                    run_valid    = 1'b0;
                    r.slot_state = slot_st[h];
                end
            end
        endcase
        r.queue_nonempty = q_has;
        return r;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        result_word_t exp_w;
        if (!rst_n)
        begin
            clear_model();
            due_results.delete();
            errors = 0;
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result word with none expected, actual %0d/%0d/%0d/%0d/%0d",
                             $time, taken_slot, taken, slot_state, ignored, queue_nonempty);
                end
                else
                begin
                    exp_w = due_results.pop_front();
                    compare_field("taken_slot", int'(exp_w.taken_slot), int'(taken_slot));
                    compare_field("taken", int'(exp_w.taken), int'(taken));
                    compare_field("slot_state", int'(exp_w.slot_state), int'(slot_state));
                    compare_field("ignored", int'(exp_w.ignored), int'(ignored));
                    compare_field("queue_nonempty", int'(exp_w.queue_nonempty),
                                  int'(queue_nonempty));
                end
            end
            if (start && !busy)
                due_results.push_back(run_command(mode, slot));
        end
        outstanding = due_results.size();
    end

endmodule

### tb/event_ready_queue_test.sv
`timescale 1ns / 100ps

module event_ready_queue_test;
    import erq_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 620;

    logic    clk;
    logic    rst_n;
    logic    start;
    mode_t   mode;
    slot_t   slot;
    logic    busy;
    logic    done;
    slot_t   taken_slot;
    logic    taken;
    sstate_t slot_state;
    logic    ignored;
    logic    queue_nonempty;
    int      errors;
    int      outstanding;
    int      gap_pct;
    int      quiet_cycles;

    event_ready_queue dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .mode           (mode),
        .slot           (slot),
        .busy           (busy),
        .done           (done),
        .taken_slot     (taken_slot),
        .taken          (taken),
        .slot_state     (slot_state),
        .ignored        (ignored),
        .queue_nonempty (queue_nonempty)
    );

    erq_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .slot           (slot),
        .done           (done),
        .taken_slot     (taken_slot),
        .taken          (taken),
        .slot_state     (slot_state),
        .ignored        (ignored),
        .queue_nonempty (queue_nonempty),
        .errors         (errors),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic issue(mode_t m, slot_t s);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            mode  <= mode_t'($urandom_range(3));
            slot  <= slot_t'($urandom_range(31));
            @(negedge clk);
        end
        start <= 1'b1;
        mode  <= m;
        slot  <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue_random();
        int    pick;
        int    k;
        mode_t m;
        slot_t s;
        pick = $urandom_range(99);
        if (pick < 38)
            m = MODE_TRIGGER;
        else if (pick < 55)
            m = MODE_CANCEL;
        else if (pick < 80)
            m = MODE_TAKE;
        else
            m = MODE_FINISH;
        // a small pool of slots keeps the list busy with repeats and mid-list cancels
        if ($urandom_range(99) < 70)
        begin
            k = $urandom_range(5);
            s = (k < 3) ? slot_t'(k) : slot_t'(26 + k);
        end
        else
            s = slot_t'($urandom_range(31));
        issue(m, s);
    endtask

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = MODE_TRIGGER;
        slot         = '0;
        gap_pct      = 10;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue, nothing running, idle cancel
        issue(MODE_TAKE, 5'd0);
        issue(MODE_FINISH, 5'd0);
        issue(MODE_CANCEL, 5'd0);
        // list 0,15,31; cancel from the middle; repeat trigger on pending
        issue(MODE_TRIGGER, 5'd0);
        issue(MODE_TRIGGER, 5'd15);
        issue(MODE_TRIGGER, 5'd31);
        issue(MODE_TRIGGER, 5'd15);
        issue(MODE_CANCEL, 5'd15);
        issue(MODE_TAKE, 5'd0);
        issue(MODE_TAKE, 5'd0);       // refused, 0 is executing
        issue(MODE_TRIGGER, 5'd0);    // retrigger
        issue(MODE_TRIGGER, 5'd0);    // already retriggered
        issue(MODE_FINISH, 5'd0);     // back to tail behind 31
        issue(MODE_TAKE, 5'd0);
        issue(MODE_CANCEL, 5'd31);    // cancel while executing
        issue(MODE_FINISH, 5'd0);
        issue(MODE_TAKE, 5'd0);
        issue(MODE_CANCEL, 5'd0);
        issue(MODE_TRIGGER, 5'd0);    // queued again while still running
        issue(MODE_FINISH, 5'd0);
        issue(MODE_TRIGGER, 5'd7);
        issue(MODE_CANCEL, 5'd7);     // tail
        issue(MODE_TRIGGER, 5'd3);
        issue(MODE_CANCEL, 5'd0);     // head
        issue(MODE_CANCEL, 5'd3);     // head and tail

        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 10 : (phase == 1) ? 70 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue_random();
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/core/erq_pkg.sv
rtl/core/erq_ram.sv
rtl/core/event_ready_queue.sv
tb/erq_checker.sv
tb/event_ready_queue_test.sv
